// ===== hw/rtl/sdq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the SDQ single-wire bus master.
// No dependencies; imported by the top level.

package sdq_pkg;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RST_LOW = 4'd1,
        PH_PDELAY  = 4'd2,
        PH_WINDOW  = 4'd3,
        PH_POST    = 4'd4,
        PH_WRITE   = 4'd5,
        PH_READ    = 4'd6,
        PH_RGAP    = 4'd7
    } phase_t;

    // Operation codes carried by a start word
    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Request type codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Timer and register widths
    localparam int TICK_W  = 12;
    localparam int CFG_IDX_W = 3;

    typedef logic [TICK_W-1:0] tick_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_RESET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_GAP    = 3'd4;

    // Register reset values
    localparam tick_t RESET_LOW_DEF   = 12'd800;
    localparam tick_t PRES_DELAY_DEF  = 12'd60;
    localparam tick_t PRES_WINDOW_DEF = 12'd300;
    localparam tick_t POST_RESET_DEF  = 12'd200;
    localparam tick_t READ_GAP_DEF    = 12'd200;

    // Slot timing in ticks
    localparam tick_t SLOT_TICKS     = 12'd118;
    localparam tick_t W1_LOW_TICKS   = 12'd11;
    localparam tick_t W0_LOW_TICKS   = 12'd104;
    localparam tick_t RD_LOW_TICKS   = 12'd7;
    localparam tick_t RD_SAMPLE_TICK = 12'd14;
    localparam tick_t RD_SLOT_TICKS  = 12'd79;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// ===== hw/rtl/sdq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// Depends on nothing but plain logic types.

interface sdq_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, req_type, operation, tx_byte, line_level, input ready);
    modport sink   (input valid, req_type, operation, tx_byte, line_level, output ready);
endinterface

interface sdq_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;

    modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                    output ready);
endinterface

// ===== hw/rtl/sdq_single_wire_master.sv =====
`timescale 1ns / 1ps
// SDQ single-wire bus master: sequencer, timers and result register.
// Depends on sdq_pkg and the channel interfaces in sdq_if.sv.
//
// Usage
//   req : request words. req_type 1 starts an operation (reset with presence
//         detect, byte write, byte read); req_type 0 is one time tick carrying
//         the sampled bus level. Starts while busy are dropped.
//   res : one result word per request word: drive_low (level for the next
//         tick), busy_res, done_res pulse, presence flag, last read byte.
//   cfg : write port for the five 12-bit timing registers; write only while
//         no operation runs.
// The result follows in the cycle after its request; one word per cycle is taken
// and returned, limited only by the single result register: a request is
// taken whenever that register is empty or being emptied in the same cycle.
// When the receiver stalls with the result register full, req.ready drops
// and the sequencer holds its state.
// Reset clears the sequencer to idle, the presence flag and the read byte,
// and loads the timing registers with their default values.

module sdq_single_wire_master
    import sdq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sdq_req_if.sink              req,
    sdq_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    // Timing registers
    tick_t reset_low_reg, pres_delay_reg, pres_window_reg, post_reset_reg, read_gap_reg;

    // Sequencer state
    phase_t     phase_reg, phase_next;
    tick_t      timer_reg, timer_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] rx_reg, rx_next;
    logic       pres_reg, pres_next;
    tick_t      window_reg, window_next;
    op_t        op_reg, op_next;

    // Phase-entry requests, resolved in order so zero-length phases chain
    logic ent_delay, ent_window, ent_post, ent_gap, ent_finish;
    logic done_next;
    logic drive_next;
    tick_t timer_inc;
    logic  start_ok;

    // Result register
    logic       out_valid_reg;
    logic       drive_reg, busy_reg, done_reg, presence_reg;
    logic [7:0] rx_out_reg;

    logic in_accept;

    assign req.ready = !out_valid_reg || res.ready;
    assign in_accept = req.valid && req.ready;
    assign timer_inc = timer_reg + 12'd1;
    assign start_ok  = (phase_reg == PH_IDLE) &&
                       (req.operation == OP_RESET || req.operation == OP_WRITE ||
                        req.operation == OP_READ);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg   <= RESET_LOW_DEF;
            pres_delay_reg  <= PRES_DELAY_DEF;
            pres_window_reg <= PRES_WINDOW_DEF;
            post_reset_reg  <= POST_RESET_DEF;
            read_gap_reg    <= READ_GAP_DEF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:   reset_low_reg   <= cfg_data;
                CFG_PRES_DELAY:  pres_delay_reg  <= cfg_data;
                CFG_PRES_WINDOW: pres_window_reg <= cfg_data;
                CFG_POST_RESET:  post_reset_reg  <= cfg_data;
                CFG_READ_GAP:    read_gap_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Next state for one word
    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        rx_next     = rx_reg;
        pres_next   = pres_reg;
        window_next = window_reg;
        op_next     = op_reg;
        ent_delay   = 1'b0;
        ent_window  = 1'b0;
        ent_post    = 1'b0;
        ent_gap     = 1'b0;
        ent_finish  = 1'b0;
        done_next   = 1'b0;

        if (req.req_type == REQ_START)
        begin
            if (start_ok)
            begin
                op_next     = op_t'(req.operation);
                timer_next  = '0;
                bit_next    = '0;
                window_next = '0;
                case (op_t'(req.operation))
                    OP_RESET:
                    begin
                        pres_next  = 1'b0;
                        shift_next = '0;
                        phase_next = PH_RST_LOW;
                    end
                    OP_WRITE:
                    begin
                        shift_next = req.tx_byte;
                        phase_next = PH_WRITE;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_READ;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_RST_LOW:
                begin
                    timer_next = timer_inc;
                    ent_delay  = (timer_inc >= reset_low_reg);
                end
                PH_PDELAY:
                begin
                    timer_next = timer_inc;
                    ent_window = (timer_inc >= pres_delay_reg);
                end
                PH_WINDOW:
                begin
                    if (!req.line_level)
                    begin
                        pres_next = 1'b1;
                        ent_post  = 1'b1;
                    end
                    else
                    begin
                        window_next = window_reg + 12'd1;
                        ent_post    = ((window_reg + 12'd1) >= pres_window_reg);
                    end
                end
                PH_POST:
                begin
                    timer_next = timer_inc;
                    ent_finish = (timer_inc >= post_reset_reg);
                end
                PH_WRITE:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= SLOT_TICKS)
                    begin
                        if (bit_reg == LAST_BIT)
                            ent_finish = 1'b1;
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            timer_next = '0;
                        end
                    end
                end
                PH_READ:
                begin
                    timer_next = timer_inc;
                    if (timer_inc == RD_SAMPLE_TICK)
                        shift_next[bit_reg] = shift_reg[bit_reg] | req.line_level;
                    if (timer_inc >= RD_SLOT_TICKS)
                    begin
                        if (bit_reg == LAST_BIT)
                            ent_gap = 1'b1;
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            timer_next = '0;
                        end
                    end
                end
                PH_RGAP:
                begin
                    timer_next = timer_inc;
                    ent_finish = (timer_inc >= read_gap_reg);
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        // Phase entry chain; zero-length phases fall through
        if (ent_delay)
        begin
            timer_next = '0;
            if (pres_delay_reg == '0)
                ent_window = 1'b1;
            else
                phase_next = PH_PDELAY;
        end
        if (ent_window)
        begin
            window_next = '0;
            if (pres_window_reg == '0)
                ent_post = 1'b1;
            else
                phase_next = PH_WINDOW;
        end
        if (ent_post)
        begin
            timer_next = '0;
            if (post_reset_reg == '0)
                ent_finish = 1'b1;
            else
                phase_next = PH_POST;
        end
        if (ent_gap)
        begin
            timer_next = '0;
            if (read_gap_reg == '0)
                ent_finish = 1'b1;
            else
                phase_next = PH_RGAP;
        end
        if (ent_finish)
        begin
            if (op_reg == OP_READ)
                rx_next = shift_next;
            phase_next = PH_IDLE;
            timer_next = '0;
            done_next  = 1'b1;
        end
    end

    // Bus drive level for the next tick, from the new state
    always_comb
    begin
        case (phase_next)
            PH_RST_LOW: drive_next = 1'b1;
            PH_WRITE:   drive_next = shift_next[bit_next] ? (timer_next < W1_LOW_TICKS)
                                                          : (timer_next < W0_LOW_TICKS);
            PH_READ:    drive_next = (timer_next < RD_LOW_TICKS);
            default:    drive_next = 1'b0;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            rx_reg     <= '0;
            pres_reg   <= 1'b0;
            window_reg <= '0;
            op_reg     <= OP_RESET;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            rx_reg     <= rx_next;
            pres_reg   <= pres_next;
            window_reg <= window_next;
            op_reg     <= op_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_reg    <= drive_next;
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= done_next;
            presence_reg <= pres_next;
            rx_out_reg   <= rx_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.drive_low = drive_reg;
    assign res.busy_res  = busy_reg;
    assign res.done_res  = done_reg;
    assign res.presence  = presence_reg;
    assign res.rx_byte   = rx_out_reg;

    // Checks
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> timer_reg == '0)
        else $error("slot timer not cleared while idle");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !busy_reg)
        else $error("completion reported while still busy");

    a_drive_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && drive_reg |-> busy_reg)
        else $error("bus driven low outside an operation");

endmodule
